@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text-mode console writer: screen
// geometry, character codes, item kinds and the control bundles between units.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int unsigned Columns   = 80;
  localparam int unsigned Rows      = 25;
  localparam int unsigned CellCount = Columns * Rows;
  localparam int unsigned CellAw    = $clog2(CellCount);
  localparam int unsigned SweepW    = $clog2(CellCount + 1);

  localparam int unsigned CellW  = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned ColW   = 7;
  localparam int unsigned RowW   = 5;
  localparam int unsigned IndexW = 11;

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharBs    = 8'h08;
  localparam logic [CharW-1:0] CharLf    = 8'h0a;
  localparam logic [CharW-1:0] CharCr    = 8'h0d;
  localparam logic [CharW-1:0] CharSpace = 8'h20;

  localparam logic KindPut  = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef struct packed {
    logic             put;
    logic [CharW-1:0] char_code;
  } cur_cmd_t;

  typedef struct packed {
    logic              wr;
    logic [CellAw-1:0] idx;
    logic              blank;
  } cur_upd_t;

  typedef struct packed {
    logic              re;
    logic [CellAw-1:0] raddr;
    logic              we;
    logic [CellAw-1:0] waddr;
    logic [CellW-1:0]  wdata;
  } ram_req_t;

endpackage

`default_nettype wire

@@ rtl/tcw_if.sv @@
// ----------------------------------------------------------------------------
// tcw_req_if / tcw_rsp_if
// Valid/ready channels of the console writer: request beats in, result
// beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tcw_pkg::CharW-1:0]     char_code;
  logic [tcw_pkg::IndexW-1:0]    cell_index;

  modport source (output valid, kind, char_code, cell_index, input ready);
  modport sink   (input valid, kind, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CellW-1:0]   cell_data;
  logic [tcw_pkg::ColW-1:0]    cursor_column;
  logic [tcw_pkg::RowW-1:0]    cursor_row;

  modport source (output valid, cell_data, cursor_column, cursor_row, input ready);
  modport sink   (input valid, cell_data, cursor_column, cursor_row, output ready);
endinterface

`default_nettype wire

@@ rtl/tcw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram (
  input  wire logic                         clk_i,
  input  wire tcw_pkg::ram_req_t            req_i,
  output logic [tcw_pkg::CellW-1:0]         rdata_o
);

  logic [tcw_pkg::CellW-1:0] mem [tcw_pkg::CellCount];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcw_cursor.sv @@
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor registers and the control-code decode of a put beat: next position,
// cell to write and whether the screen must be blanked.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tcw_pkg::cur_cmd_t          cmd_i,
  output tcw_pkg::cur_upd_t               upd_o,
  output logic [tcw_pkg::ColW-1:0]        col_o,
  output logic [tcw_pkg::RowW-1:0]        row_o
);

  localparam logic [tcw_pkg::CellAw-1:0] ColsA = tcw_pkg::CellAw'(tcw_pkg::Columns);

  logic [tcw_pkg::ColW-1:0] col_q, col_d;
  logic [tcw_pkg::RowW-1:0] row_q, row_d;
  logic [tcw_pkg::ColW:0]   c;
  logic [tcw_pkg::RowW:0]   r;

  always_comb begin
    c         = {1'b0, col_q};
    r         = {1'b0, row_q};
    upd_o.wr    = 1'b0;
    upd_o.blank = 1'b0;
    upd_o.idx   = tcw_pkg::CellAw'(row_q) * ColsA + tcw_pkg::CellAw'(col_q);
    case (cmd_i.char_code)
      tcw_pkg::CharNul: begin
      end
      tcw_pkg::CharLf: begin
        c = '0;
        r = r + 1'b1;
      end
      tcw_pkg::CharBs: begin
        if (c != '0) begin
          c = c - 1'b1;
        end
      end
      tcw_pkg::CharCr: begin
        r = r + 1'b1;
      end
      default: begin
        upd_o.wr = 1'b1;
        c        = c + 1'b1;
      end
    endcase
    if (c >= tcw_pkg::Columns) begin
      c = '0;
      r = r + 1'b1;
    end
    if (r >= tcw_pkg::Rows) begin
      upd_o.blank = 1'b1;
      c           = '0;
      r           = '0;
    end
    col_d = c[tcw_pkg::ColW-1:0];
    row_d = r[tcw_pkg::RowW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.put) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

`default_nettype wire

@@ rtl/text_mode_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// 80x25 text console writer: puts characters at the cursor with newline,
// backspace and row-advance codes, blanks the screen on overflow past the
// last row, and reads back single cells.
//
//   channel  dir  beat
//   req_i    in   kind, char_code, cell_index
//   rsp_o    out  cell_data, cursor_column, cursor_row
//
// a beat: cell read at accept, then write-back and result in the access state
// a put that runs past the last row adds a blanking sweep that writes a space
// into each cell, each read of a cell beside the write-back of the one before
// after reset a clearing pass zeroes the cell ram, req_i stalls
// a stalled result stalls the write-back cycle and with it the next request
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_console_writer_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcw_req_if.sink    req_i,
  tcw_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {StClear, StIdle, StAccess, StBlank} state_e;

  state_e                         state_q;
  logic [tcw_pkg::SweepW-1:0]     cnt_q;
  logic                           kind_q;
  logic                           wr_q;
  logic [tcw_pkg::CellAw-1:0]     widx_q;
  logic [tcw_pkg::CharW-1:0]      wch_q;
  logic                           blank_q;
  logic                           rd_ok_q;
  logic                           out_valid_q;
  logic [tcw_pkg::CellW-1:0]      out_data_q;
  logic [tcw_pkg::ColW-1:0]       out_col_q;
  logic [tcw_pkg::RowW-1:0]       out_row_q;

  logic                           accept;
  logic                           slot_free;
  tcw_pkg::cur_cmd_t              cur_cmd;
  tcw_pkg::cur_upd_t              cur_upd;
  logic [tcw_pkg::ColW-1:0]       cur_col;
  logic [tcw_pkg::RowW-1:0]       cur_row;
  tcw_pkg::ram_req_t              ram_req;
  logic [tcw_pkg::CellW-1:0]      ram_rdata;
  logic [tcw_pkg::SweepW-1:0]     cnt_prev;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign cnt_prev    = cnt_q - 1'b1;

  assign cur_cmd.put       = accept && (req_i.kind == tcw_pkg::KindPut);
  assign cur_cmd.char_code = req_i.char_code;

  tcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .upd_o  (cur_upd),
    .col_o  (cur_col),
    .row_o  (cur_row)
  );

  always_comb begin
    ram_req = '0;
    case (state_q)
      StClear: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q[tcw_pkg::CellAw-1:0];
        ram_req.wdata = '0;
      end
      StIdle: begin
        ram_req.re    = accept;
        ram_req.raddr = (req_i.kind == tcw_pkg::KindRead) ?
                        req_i.cell_index[tcw_pkg::CellAw-1:0] : cur_upd.idx;
      end
      StAccess: begin
        ram_req.we    = wr_q && slot_free;
        ram_req.waddr = widx_q;
        ram_req.wdata = {ram_rdata[tcw_pkg::CellW-1:tcw_pkg::CharW], wch_q};
      end
      StBlank: begin
        ram_req.re    = (cnt_q < tcw_pkg::CellCount);
        ram_req.raddr = cnt_q[tcw_pkg::CellAw-1:0];
        ram_req.we    = (cnt_q != '0);
        ram_req.waddr = cnt_prev[tcw_pkg::CellAw-1:0];
        ram_req.wdata = {ram_rdata[tcw_pkg::CellW-1:tcw_pkg::CharW], tcw_pkg::CharSpace};
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  tcw_cell_ram u_cell_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      kind_q      <= tcw_pkg::KindPut;
      wr_q        <= 1'b0;
      blank_q     <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready && !((state_q == StAccess) && slot_free)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == tcw_pkg::SweepW'(tcw_pkg::CellCount - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (accept) begin
            kind_q  <= req_i.kind;
            wr_q    <= cur_cmd.put && cur_upd.wr;
            blank_q <= cur_cmd.put && cur_upd.blank;
            widx_q  <= cur_upd.idx;
            wch_q   <= req_i.char_code;
            rd_ok_q <= (req_i.cell_index < tcw_pkg::CellCount);
            state_q <= StAccess;
          end
        end
        StAccess: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= ((kind_q == tcw_pkg::KindRead) && rd_ok_q) ? ram_rdata : '0;
            out_col_q   <= cur_col;
            out_row_q   <= cur_row;
            cnt_q       <= '0;
            state_q     <= blank_q ? StBlank : StIdle;
          end
        end
        StBlank: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == tcw_pkg::SweepW'(tcw_pkg::CellCount)) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.cell_data     = out_data_q;
  assign rsp_o.cursor_column = out_col_q;
  assign rsp_o.cursor_row    = out_row_q;

endmodule

`default_nettype wire
